// ----- src/ghpd_pkg.sv -----
// ----------------------------------------------------------------------------
// ghpd_pkg
// Types, register codes, reset values and the microcode program shared by the
// gyro heading PD steering block.
// ----------------------------------------------------------------------------
package ghpd_pkg;

    typedef struct packed {
        logic signed [15:0] gyro_rate;
        logic        [19:0] dt_us;
        logic               rebase;
    } sample_t;

    typedef struct packed {
        logic        [1:0]  steer_dir;
        logic        [7:0]  steer_pwm;
        logic signed [31:0] yaw_out;
        logic signed [31:0] heading_error;
    } result_t;

    typedef enum logic [2:0] {
        REG_GYRO_OFFSET,
        REG_FILTER_ALPHA,
        REG_RATE_DEADZONE,
        REG_RATE_SCALE,
        REG_KP,
        REG_KD,
        REG_STEER_CEIL,
        REG_STEER_FLOOR
    } reg_idx_t;

    typedef struct packed {
        reg_idx_t    index;
        logic [15:0] value;
    } cfg_t;

    localparam logic [1:0] DIR_OFF   = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;

    localparam logic signed [15:0] RST_GYRO_OFFSET   = 16'sd0;
    localparam logic        [8:0]  RST_FILTER_ALPHA  = 9'd38;
    localparam logic        [14:0] RST_RATE_DEADZONE = 15'd11;
    localparam logic        [15:0] RST_RATE_SCALE    = 16'd16786;
    localparam logic        [15:0] RST_KP            = 16'd1280;
    localparam logic        [15:0] RST_KD            = 16'd768;
    localparam logic        [7:0]  RST_STEER_CEIL    = 8'd220;
    localparam logic        [7:0]  RST_STEER_FLOOR   = 8'd140;

    localparam logic [19:0] DT_MIN_US = 20'd1000;
    localparam logic [19:0] DT_MAX_US = 20'd100000;
    localparam logic [8:0]  ALPHA_ONE = 9'd256;

    // shared multiplier and accumulator widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 19;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 60;
    localparam int P_W     = 36;
    localparam int P_HALF  = P_W / 2;

    typedef logic [3:0] step_t;

    localparam step_t STEP_PD   = 4'd9;
    localparam step_t LAST_STEP = 4'd13;

    typedef enum logic [2:0] {
        M_NONE,
        M_DTSC,
        M_ARAW,
        M_BF,
        M_UPHI,
        M_UPLO,
        M_KPE,
        M_KDD
    } mul_sel_t;

    typedef enum logic [2:0] {
        A_HOLD,
        A_LOAD,
        A_ADD,
        A_ADD_SH8,
        A_LOAD_SH18
    } acc_op_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_NOWIN,
        J_END
    } jmp_t;

    typedef struct packed {
        mul_sel_t msel;
        acc_op_t  aop;
        logic     wr_p;
        logic     wr_filt;
        logic     wr_yaw;
        logic     wr_err;
        logic     wr_prev;
        logic     wr_out;
        jmp_t     jmp;
        step_t    target;
    } ctrl_t;

    function automatic ctrl_t ucode(step_t s);
        ctrl_t c;
        c = '0;
        c.msel = M_NONE;
        c.aop  = A_HOLD;
        c.jmp  = J_NEXT;
        case (s)
            4'd0:  c.msel = M_DTSC;
            4'd1:
            begin
                c.wr_p = 1'b1;
                c.msel = M_ARAW;
            end
            4'd2:
            begin
                c.aop  = A_LOAD;
                c.msel = M_BF;
            end
            4'd3:  c.aop = A_ADD_SH8;
            4'd4:
            begin
                c.wr_filt = 1'b1;
                c.jmp     = J_NOWIN;
                c.target  = STEP_PD;
            end
            4'd5:  c.msel = M_UPHI;
            4'd6:
            begin
                c.aop  = A_LOAD_SH18;
                c.msel = M_UPLO;
            end
            4'd7:  c.aop = A_ADD;
            4'd8:  c.wr_yaw = 1'b1;
            4'd9:  c.wr_err = 1'b1;
            4'd10: c.msel = M_KPE;
            4'd11:
            begin
                c.aop  = A_LOAD;
                c.msel = M_KDD;
            end
            4'd12:
            begin
                c.aop     = A_ADD;
                c.wr_prev = 1'b1;
            end
            4'd13:
            begin
                c.wr_out = 1'b1;
                c.jmp    = J_END;
            end
            default: c.jmp = J_END;
        endcase
        return c;
    endfunction

endpackage

// ----- src/ghpd_stream_if.sv -----
// ----------------------------------------------------------------------------
// ghpd_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface ghpd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/ghpd_seq.sv -----
// ----------------------------------------------------------------------------
// ghpd_seq
// Microcode sequencer: step counter, program ROM and jumps. Issues one
// control word per cycle while busy, unless hold keeps it at the last step.
// ----------------------------------------------------------------------------
module ghpd_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            window,
    input  logic            hold,
    output logic            busy,
    output ghpd_pkg::ctrl_t ctrl
);
    import ghpd_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  busy_reg;
    logic  busy_next;
    ctrl_t word;

    assign word = ucode(step_reg);
    assign busy = busy_reg;

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        ctrl      = '0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            ctrl = word;
            unique case (word.jmp)
                J_NEXT:  step_next = step_reg + 1'b1;
                J_NOWIN: step_next = window ? step_reg + 1'b1 : word.target;
                J_END:
                begin
                    if (hold)
                    begin
                        ctrl.wr_out = 1'b0;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                        step_next = '0;
                    end
                end
                default: step_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg <= LAST_STEP))
        else $error("step counter past end of program");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("transaction started while busy");

    a_end_release: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && word.jmp == J_END && !hold) |=> !busy_reg)
        else $error("sequencer did not release after last step");

    a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        hold |-> !ctrl.wr_out)
        else $error("result written over a pending result");

endmodule

// ----- src/gyro_heading_pd_steering.sv -----
// ----------------------------------------------------------------------------
// gyro_heading_pd_steering
// Gyro yaw integration and PD heading loop driving steering direction and PWM.
// ----------------------------------------------------------------------------
// One sample transaction in, one result transaction out. A sample is processed
// by a 14-step microcode program around a single shared 34x19 multiplier: yaw
// is integrated only when 1000 < dt_us < 100000, else the yaw steps are
// skipped. A new sample can be taken from the cycle after the result is
// registered, not before; the last step waits while a previous result has not
// been taken. Configuration writes are taken every cycle and must only be made
// while idle.
module gyro_heading_pd_steering #(
    parameter int YAW_FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    ghpd_stream_if.sink   sample,
    ghpd_stream_if.source result,
    ghpd_stream_if.sink   cfg
);
    import ghpd_pkg::*;

    localparam int YAW_SHIFT = 48 - YAW_FRAC_BITS;
    localparam int PD_SHIFT  = 8 + YAW_FRAC_BITS;

    logic signed [15:0] offset_reg;
    logic        [8:0]  alpha_reg;
    logic        [14:0] dz_reg;
    logic        [15:0] scale_reg;
    logic        [15:0] kp_reg;
    logic        [15:0] kd_reg;
    logic        [7:0]  max_reg;
    logic        [7:0]  min_reg;

    logic signed [31:0] yaw_reg;
    logic signed [23:0] filt_reg;
    logic signed [31:0] target_reg;
    logic signed [31:0] prev_reg;

    logic signed [15:0]       rate_reg;
    logic        [19:0]       dt_reg;
    logic signed [23:0]       use_reg;
    logic signed [31:0]       err_reg;
    logic        [P_W-1:0]    p_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [PROD_W-1:0] prod_reg;

    result_t res_reg;
    logic    out_valid_reg;

    logic  start;
    logic  busy;
    logic  window;
    logic  hold;
    ctrl_t ctrl;

    logic signed [16:0]        raw;
    logic        [8:0]         a_eff;
    logic        [8:0]         a_inv;
    logic signed [32:0]        deriv;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   prod_sh8;

    logic signed [23:0]      filt_sat;
    logic        [23:0]      filt_abs;
    logic signed [23:0]      use_next;
    logic signed [ACC_W-1:0] delta;
    logic signed [ACC_W-1:0] yaw_sum;
    logic signed [31:0]      yaw_sat;
    logic signed [32:0]      err_diff;
    logic signed [31:0]      err_sat;
    logic        [ACC_W-1:0] sum_abs;
    logic        [ACC_W-1:0] mag;
    logic        [7:0]       mag_lim;
    result_t                 res_next;

    assign cfg.ready    = 1'b1;
    assign sample.ready = !busy;
    assign start        = sample.valid && !busy;
    assign result.valid = out_valid_reg;
    assign result.data  = res_reg;
    assign hold         = out_valid_reg && !result.ready;
    assign window       = (dt_reg > DT_MIN_US) && (dt_reg < DT_MAX_US);

    ghpd_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .window (window),
        .hold   (hold),
        .busy   (busy),
        .ctrl   (ctrl)
    );

    // operand preparation
    assign raw   = {rate_reg[15], rate_reg} - {offset_reg[15], offset_reg};
    assign a_eff = alpha_reg[8] ? ALPHA_ONE : alpha_reg;
    assign a_inv = ALPHA_ONE - a_eff;
    assign deriv = {err_reg[31], err_reg} - {prev_reg[31], prev_reg};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.msel)
            M_DTSC:
            begin
                mul_a = {{(MUL_A_W - 20){1'b0}}, dt_reg};
                mul_b = {{(MUL_B_W - 16){1'b0}}, scale_reg};
            end
            M_ARAW:
            begin
                mul_a = {{(MUL_A_W - 17){raw[16]}}, raw};
                mul_b = {{(MUL_B_W - 9){1'b0}}, a_eff};
            end
            M_BF:
            begin
                mul_a = {{(MUL_A_W - 24){filt_reg[23]}}, filt_reg};
                mul_b = {{(MUL_B_W - 9){1'b0}}, a_inv};
            end
            M_UPHI:
            begin
                mul_a = {{(MUL_A_W - 24){use_reg[23]}}, use_reg};
                mul_b = {{(MUL_B_W - P_HALF){1'b0}}, p_reg[P_W-1:P_HALF]};
            end
            M_UPLO:
            begin
                mul_a = {{(MUL_A_W - 24){use_reg[23]}}, use_reg};
                mul_b = {{(MUL_B_W - P_HALF){1'b0}}, p_reg[P_HALF-1:0]};
            end
            M_KPE:
            begin
                mul_a = {{(MUL_A_W - 32){err_reg[31]}}, err_reg};
                mul_b = {{(MUL_B_W - 16){1'b0}}, kp_reg};
            end
            M_KDD:
            begin
                mul_a = {{(MUL_A_W - 33){deriv[32]}}, deriv};
                mul_b = {{(MUL_B_W - 16){1'b0}}, kd_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_ext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign prod_sh8 = {{(ACC_W - PROD_W + 8){prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:8]};

    always_comb
    begin
        acc_next = acc_reg;
        case (ctrl.aop)
            A_LOAD:      acc_next = prod_ext;
            A_ADD:       acc_next = acc_reg + prod_ext;
            A_ADD_SH8:   acc_next = acc_reg + prod_sh8;
            A_LOAD_SH18: acc_next = {prod_ext[ACC_W-1-P_HALF:0], {P_HALF{1'b0}}};
            default:     acc_next = acc_reg;
        endcase
    end

    // filter result, saturation and deadzone
    always_comb
    begin
        if (&acc_reg[ACC_W-1:23] || ~|acc_reg[ACC_W-1:23])
            filt_sat = acc_reg[23:0];
        else
            filt_sat = acc_reg[ACC_W-1] ? 24'sh800000 : 24'sh7FFFFF;
        filt_abs = filt_sat[23] ? (~filt_sat + 24'd1) : filt_sat;
        use_next = (filt_abs > {1'b0, dz_reg, 8'b0}) ? filt_sat : 24'sd0;
    end

    // yaw update
    always_comb
    begin
        delta   = acc_reg >>> YAW_SHIFT;
        yaw_sum = {{(ACC_W - 32){yaw_reg[31]}}, yaw_reg} + delta;
        if (&yaw_sum[ACC_W-1:31] || ~|yaw_sum[ACC_W-1:31])
            yaw_sat = yaw_sum[31:0];
        else
            yaw_sat = yaw_sum[ACC_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end

    // heading error
    always_comb
    begin
        err_diff = {target_reg[31], target_reg} - {yaw_reg[31], yaw_reg};
        if (err_diff[32] == err_diff[31])
            err_sat = err_diff[31:0];
        else
            err_sat = err_diff[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end

    // steering output
    always_comb
    begin
        sum_abs = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
        mag     = sum_abs >> PD_SHIFT;
        mag_lim = (mag > {{(ACC_W - 8){1'b0}}, max_reg}) ? max_reg : mag[7:0];
        res_next.yaw_out       = yaw_reg;
        res_next.heading_error = err_reg;
        if (mag_lim == 8'd0)
        begin
            res_next.steer_dir = DIR_OFF;
            res_next.steer_pwm = 8'd0;
        end
        else
        begin
            res_next.steer_dir = acc_reg[ACC_W-1] ? DIR_RIGHT : DIR_LEFT;
            res_next.steer_pwm = (mag_lim < min_reg) ? min_reg : mag_lim;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= RST_GYRO_OFFSET;
            alpha_reg  <= RST_FILTER_ALPHA;
            dz_reg     <= RST_RATE_DEADZONE;
            scale_reg  <= RST_RATE_SCALE;
            kp_reg     <= RST_KP;
            kd_reg     <= RST_KD;
            max_reg    <= RST_STEER_CEIL;
            min_reg    <= RST_STEER_FLOOR;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                REG_GYRO_OFFSET:   offset_reg <= cfg.data.value;
                REG_FILTER_ALPHA:  alpha_reg  <= cfg.data.value[8:0];
                REG_RATE_DEADZONE: dz_reg     <= cfg.data.value[14:0];
                REG_RATE_SCALE:    scale_reg  <= cfg.data.value;
                REG_KP:            kp_reg     <= cfg.data.value;
                REG_KD:            kd_reg     <= cfg.data.value;
                REG_STEER_CEIL:    max_reg    <= cfg.data.value[7:0];
                REG_STEER_FLOOR:   min_reg    <= cfg.data.value[7:0];
                default:           min_reg    <= min_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_reg       <= '0;
            filt_reg      <= '0;
            target_reg    <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (start && sample.data.rebase)
            begin
                target_reg <= yaw_reg;
                prev_reg   <= '0;
            end
            else if (ctrl.wr_prev)
            begin
                prev_reg <= err_reg;
            end
            if (ctrl.wr_filt)
                filt_reg <= filt_sat;
            if (ctrl.wr_yaw)
                yaw_reg <= yaw_sat;
            if (ctrl.wr_out)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rate_reg <= sample.data.gyro_rate;
            dt_reg   <= sample.data.dt_us;
        end
        prod_reg <= mul_p;
        acc_reg  <= acc_next;
        if (ctrl.wr_p)
            p_reg <= prod_reg[P_W-1:0];
        if (ctrl.wr_filt)
            use_reg <= use_next;
        if (ctrl.wr_err)
            err_reg <= err_sat;
        if (ctrl.wr_out)
            res_reg <= res_next;
    end

endmodule

// ----- tb/gyro_heading_pd_steering_tb.sv -----
// ----------------------------------------------------------------------------
// gyro_heading_pd_steering_tb
// Self-checking bench for the gyro heading PD steering block. A queue-fed
// driver offers gyro samples with random gaps and a ready-toggling sink takes
// results. A predictor tracks filter, yaw, target and PD state for every
// accepted sample transaction, and each result transaction is checked field
// by field. Register settings are changed only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gyro_heading_pd_steering_tb;

    import ghpd_pkg::*;

    localparam int YAW_FRAC_BITS = 16;
    localparam int LONG_HOLD     = 300;

    logic clk;
    logic rst_n;

    ghpd_stream_if #(.payload_t(sample_t)) sample_if ();
    ghpd_stream_if #(.payload_t(result_t)) result_if ();
    ghpd_stream_if #(.payload_t(cfg_t))    cfg_if ();

    gyro_heading_pd_steering #(
        .YAW_FRAC_BITS(YAW_FRAC_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(sample_if),
        .result(result_if),
        .cfg   (cfg_if)
    );

    sample_t pending_samples[$];
    result_t expected_results[$];
    result_t want;
    int      queued_count;
    int      accepted_count;
    int      fail_count;
    int      send_gap;
    int      rx_stall;
    logic    sample_taken;
    bit      no_idle;
    bit      hold_req;
    bit      hold_ack;
    logic [15:0] reg_plan [8];

    // predictor copy of configuration and state
    logic signed [15:0] cfg_offset;
    logic        [8:0]  cfg_alpha;
    logic        [14:0] cfg_deadzone;
    logic        [15:0] cfg_scale;
    logic        [15:0] cfg_kp;
    logic        [15:0] cfg_kd;
    logic        [7:0]  cfg_max;
    logic        [7:0]  cfg_min;
    logic signed [31:0] yaw_q;
    logic signed [23:0] filt_q;
    logic signed [31:0] target_q;
    logic signed [31:0] prev_err_q;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("gyro_heading_pd_steering_tb failed");
        $finish;
    end

    function automatic longint clamp_signed(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic result_t predict_steering(sample_t s);
        longint  alpha;
        longint  raw;
        longint  acc;
        longint  rate_used;
        longint  mag;
        longint  delta;
        longint  err;
        longint  deriv;
        longint  pd_sum;
        result_t r;
        if (s.rebase)
        begin
            target_q   = yaw_q;
            prev_err_q = '0;
        end
        alpha = longint'(cfg_alpha);
        if (alpha > longint'(ALPHA_ONE))
            alpha = longint'(ALPHA_ONE);
        raw    = longint'($signed(s.gyro_rate)) - longint'(cfg_offset);
        acc    = alpha * raw * 256 + (256 - alpha) * longint'(filt_q);
        filt_q = 24'(clamp_signed(acc >>> 8, 24));

        rate_used = longint'(filt_q);
        mag       = (rate_used < 0) ? -rate_used : rate_used;
        if (mag <= (longint'(cfg_deadzone) <<< 8))
            rate_used = 0;

        if (s.dt_us > DT_MIN_US && s.dt_us < DT_MAX_US)
        begin
            delta = (rate_used * longint'(s.dt_us) * longint'(cfg_scale))
                    >>> (48 - YAW_FRAC_BITS);
            yaw_q = 32'(clamp_signed(longint'(yaw_q) + delta, 32));
        end

        err        = clamp_signed(longint'(target_q) - longint'(yaw_q), 32);
        deriv      = err - longint'(prev_err_q);
        prev_err_q = 32'(err);
        pd_sum     = longint'(cfg_kp) * err + longint'(cfg_kd) * deriv;
        mag        = ((pd_sum < 0) ? -pd_sum : pd_sum) >>> (8 + YAW_FRAC_BITS);
        if (mag > longint'(cfg_max))
            mag = longint'(cfg_max);

        r.steer_dir = DIR_OFF;
        r.steer_pwm = '0;
        if (mag >= 1)
        begin
            r.steer_dir = (pd_sum < 0) ? DIR_RIGHT : DIR_LEFT;
            r.steer_pwm = (mag < longint'(cfg_min)) ? cfg_min : 8'(mag);
        end
        r.yaw_out       = yaw_q;
        r.heading_error = 32'(err);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sample driver
    always @(negedge clk)
    begin
        if (sample_if.valid && !sample_taken)
        begin
            // transaction still waiting for ready
        end
        else if (send_gap > 0)
        begin
            sample_if.valid <= 1'b0;
            send_gap--;
        end
        else if (pending_samples.size() != 0)
        begin
            sample_if.valid <= 1'b1;
            sample_if.data  <= pending_samples.pop_front();
            send_gap = pick_gap();
        end
        else
        begin
            sample_if.valid <= 1'b0;
        end
    end

    // result sink
    always @(negedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack = hold_req;
            rx_stall = LONG_HOLD;
        end
        if (rx_stall > 0)
        begin
            result_if.ready <= 1'b0;
            rx_stall--;
        end
        else
        begin
            result_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                rx_stall = pick_gap();
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        sample_taken <= sample_if.valid && sample_if.ready;
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                case (cfg_if.data.index)
                    REG_GYRO_OFFSET:   cfg_offset   = cfg_if.data.value;
                    REG_FILTER_ALPHA:  cfg_alpha    = cfg_if.data.value[8:0];
                    REG_RATE_DEADZONE: cfg_deadzone = cfg_if.data.value[14:0];
                    REG_RATE_SCALE:    cfg_scale    = cfg_if.data.value;
                    REG_KP:            cfg_kp       = cfg_if.data.value;
                    REG_KD:            cfg_kd       = cfg_if.data.value;
                    REG_STEER_CEIL:    cfg_max      = cfg_if.data.value[7:0];
                    REG_STEER_FLOOR:   cfg_min      = cfg_if.data.value[7:0];
                    default: ;
                endcase
            end
            if (result_if.valid && result_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_if.data.steer_dir !== want.steer_dir)
                    begin
                        $error("steer_dir: expected %0d, got %0d",
                               want.steer_dir, result_if.data.steer_dir);
                        fail_count++;
                    end
                    if (result_if.data.steer_pwm !== want.steer_pwm)
                    begin
                        $error("steer_pwm: expected %0d, got %0d",
                               want.steer_pwm, result_if.data.steer_pwm);
                        fail_count++;
                    end
                    if (result_if.data.yaw_out !== want.yaw_out)
                    begin
                        $error("yaw_out: expected %0d, got %0d",
                               want.yaw_out, result_if.data.yaw_out);
                        fail_count++;
                    end
                    if (result_if.data.heading_error !== want.heading_error)
                    begin
                        $error("heading_error: expected %0d, got %0d",
                               want.heading_error, result_if.data.heading_error);
                        fail_count++;
                    end
                end
            end
            if (sample_if.valid && sample_if.ready)
            begin
                expected_results.push_back(predict_steering(sample_if.data));
                accepted_count++;
            end
        end
    end

    task automatic queue_sample(input logic [15:0] rate, input logic [19:0] dt,
                                input logic reb);
        sample_t s;
        s.gyro_rate = rate;
        s.dt_us     = dt;
        s.rebase    = reb;
        pending_samples.push_back(s);
        queued_count++;
    endtask

    task automatic queue_random_sample();
        bit [31:0]   u;
        int          pick;
        logic [15:0] rate;
        logic [19:0] dt;
        pick = $urandom_range(0, 99);
        u    = $urandom();
        if (pick < 50)
            rate = 16'(int'(cfg_offset) + int'(u[11:0]) - 2048);
        else if (pick < 80)
            rate = u[16] ? -{1'b0, u[14:0]} : {1'b0, u[14:0]};
        else
            rate = u[15:0];
        pick = $urandom_range(0, 99);
        u    = $urandom();
        if (pick < 75)
            dt = 20'($urandom_range(1001, 99999));
        else if (pick < 87)
        begin
            case (u[1:0])
                2'd0:    dt = DT_MIN_US;
                2'd1:    dt = DT_MIN_US + 20'd1;
                2'd2:    dt = DT_MAX_US - 20'd1;
                default: dt = DT_MAX_US;
            endcase
        end
        else
            dt = u[19:0];
        queue_sample(rate, dt, $urandom_range(0, 15) == 0);
    endtask

    // large steady rate near the top of the integration window
    task automatic queue_spin_sample(input bit negative, input logic reb);
        logic [15:0] rate;
        rate = 16'($urandom_range(30000, 32767));
        if (negative)
            rate = -rate;
        queue_sample(rate, 20'($urandom_range(90000, 99999)), reb);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_if.valid      <= 1'b1;
        cfg_if.data.index <= idx;
        cfg_if.data.value <= value;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_regs();
        for (int i = 0; i < 8; i++)
            write_reg(reg_idx_t'(i), reg_plan[i]);
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (accepted_count != queued_count || expected_results.size() != 0);
        repeat (4) @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        bit [31:0] u;
        rst_n           = 1'b0;
        sample_if.valid = 1'b0;
        sample_if.data  = '0;
        result_if.ready = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.data     = '0;
        sample_taken    = 1'b0;
        send_gap        = 0;
        rx_stall        = 0;
        no_idle         = 1'b0;
        hold_req        = 1'b0;
        hold_ack        = 1'b0;
        queued_count    = 0;
        accepted_count  = 0;
        fail_count      = 0;
        cfg_offset      = RST_GYRO_OFFSET;
        cfg_alpha       = RST_FILTER_ALPHA;
        cfg_deadzone    = RST_RATE_DEADZONE;
        cfg_scale       = RST_RATE_SCALE;
        cfg_kp          = RST_KP;
        cfg_kd          = RST_KD;
        cfg_max         = RST_STEER_CEIL;
        cfg_min         = RST_STEER_FLOOR;
        yaw_q           = '0;
        filt_q          = '0;
        target_q        = '0;
        prev_err_q      = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // integration window edges and field extremes
        queue_sample(16'h0000, 20'd0, 1'b0);
        queue_sample(16'h7FFF, DT_MIN_US + 20'd1, 1'b0);
        queue_sample(16'h8000, DT_MAX_US - 20'd1, 1'b0);
        queue_sample(16'h7FFF, DT_MIN_US, 1'b0);
        queue_sample(16'h7FFF, DT_MAX_US, 1'b0);
        queue_sample(16'h8000, 20'hFFFFF, 1'b1);
        queue_sample(16'd100, 20'd5000, 1'b1);
        queue_sample(-16'sd100, 20'd5000, 1'b0);
        wait_idle();

        // deadzone boundary with an unfiltered rate
        write_reg(REG_FILTER_ALPHA, 16'(ALPHA_ONE));
        queue_sample(16'd11, 20'd20000, 1'b0);
        queue_sample(16'd12, 20'd20000, 1'b0);
        queue_sample(-16'sd11, 20'd20000, 1'b0);
        queue_sample(-16'sd12, 20'd20000, 1'b1);
        queue_sample(16'd0, 20'd20000, 1'b0);
        wait_idle();

        // steering floor above the ceiling
        write_reg(REG_STEER_FLOOR, 16'd250);
        queue_sample(16'd3000, 20'd50000, 1'b0);
        queue_sample(-16'sd3000, 20'd50000, 1'b0);
        queue_sample(16'd0, 20'd50000, 1'b1);
        wait_idle();

        // drive yaw into positive saturation, rebase there, then swing back
        // until the heading error saturates
        reg_plan = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                     16'hFFFF, 16'hFFFF, 16'h00FF, 16'h0000};
        program_regs();
        for (int i = 0; i < 230; i++)
            queue_spin_sample(1'b0, 1'b0);
        queue_spin_sample(1'b1, 1'b1);
        for (int i = 0; i < 230; i++)
            queue_spin_sample(1'b1, 1'b0);
        wait_idle();

        // low extremes: frozen filter, no gain, steering ceiling zero
        reg_plan = '{16'h7FFF, 16'h0000, 16'hFFFF, 16'h0000,
                     16'h0000, 16'h0000, 16'h0000, 16'h00FF};
        program_regs();
        for (int i = 0; i < 40; i++)
            queue_random_sample();
        wait_idle();

        // back-to-back transactions with no idling on either side
        u = $urandom();
        reg_plan = '{16'h8000, 16'(ALPHA_ONE), {10'd0, u[5:0]}, 16'($urandom()),
                     16'($urandom()), 16'($urandom()), 16'd200, 16'd250};
        program_regs();
        no_idle = 1'b1;
        for (int i = 0; i < 80; i++)
            queue_random_sample();
        wait_idle();
        no_idle = 1'b0;

        // fully random registers; sink holds off while samples keep coming
        for (int i = 0; i < 8; i++)
        begin
            u = $urandom();
            reg_plan[i] = u[15:0];
        end
        program_regs();
        for (int i = 0; i < 100; i++)
            queue_random_sample();
        hold_req = ~hold_req;
        wait_idle();

        // reset values with a small bias
        u = $urandom();
        reg_plan = '{16'(int'(u[9:0]) - 512), 16'(RST_FILTER_ALPHA),
                     16'(RST_RATE_DEADZONE), RST_RATE_SCALE,
                     RST_KP, RST_KD, 16'(RST_STEER_CEIL), 16'(RST_STEER_FLOOR)};
        program_regs();
        for (int i = 0; i < 50; i++)
            queue_random_sample();
        wait_idle();

        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("gyro_heading_pd_steering_tb passed");
        else
            $display("gyro_heading_pd_steering_tb failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ghpd_pkg.sv
src/ghpd_stream_if.sv
src/ghpd_seq.sv
src/gyro_heading_pd_steering.sv
tb/gyro_heading_pd_steering_tb.sv
